### rtl/core/wav_header_and_sample_parser_assert.svh
// Assertion helpers shared by the parser blocks.
`ifndef WAV_HEADER_AND_SAMPLE_PARSER_ASSERT_SVH
`define WAV_HEADER_AND_SAMPLE_PARSER_ASSERT_SVH

// Condition must hold on every clock edge outside reset.
`define WAVP_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next.
`define WAVP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/wavp_pkg.sv
`timescale 1ns / 1ps

package wavp_pkg;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_SAMPLES = 2'd1,
        PH_IDLE    = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    localparam logic [5:0] OFF_FORMAT_HI = 6'd21;
    localparam logic [5:0] OFF_CHAN_HI   = 6'd23;
    localparam logic [5:0] OFF_RATE_HI   = 6'd27;
    localparam logic [5:0] OFF_BITS_HI   = 6'd35;
    localparam logic [5:0] OFF_HDR_LAST  = 6'd43;

    localparam logic [31:0] TAG_RIFF = "RIFF";
    localparam logic [31:0] TAG_WAVE = "WAVE";
    localparam logic [31:0] TAG_FMT  = "fmt ";
    localparam logic [31:0] TAG_DATA = "data";

    typedef struct packed {
        logic       check;
        logic [7:0] value;
    } tag_byte_t;

    typedef struct packed {
        kind_t              kind;
        logic [15:0]        audio_format;
        logic [15:0]        channel_count;
        logic [31:0]        sample_rate;
        logic [15:0]        bits_per_sample;
        logic [30:0]        sample_total;
        logic signed [15:0] sample_value;
        logic [30:0]        sample_index;
        logic               last_flag;
        logic [5:0]         error_position;
    } result_t;

    // Tags start on 4-byte boundaries, so the low two offset bits pick the char.
    function automatic logic [7:0] tag_char(input logic [31:0] tag, input logic [1:0] pos);
        logic [7:0] c;
        case (pos)
            2'd0:    c = tag[31:24];
            2'd1:    c = tag[23:16];
            2'd2:    c = tag[15:8];
            default: c = tag[7:0];
        endcase
        return c;
    endfunction

    function automatic tag_byte_t tag_lookup(input logic [5:0] off);
        tag_byte_t t;
        t.check = 1'b1;
        case (off) inside
            [6'd0:6'd3]:   t.value = tag_char(TAG_RIFF, off[1:0]);
            [6'd8:6'd11]:  t.value = tag_char(TAG_WAVE, off[1:0]);
            [6'd12:6'd15]: t.value = tag_char(TAG_FMT, off[1:0]);
            [6'd36:6'd39]: t.value = tag_char(TAG_DATA, off[1:0]);
            default:
            begin
                t.check = 1'b0;
                t.value = 8'd0;
            end
        endcase
        return t;
    endfunction

endpackage

### rtl/core/wavp_parse.sv
`timescale 1ns / 1ps

`include "wav_header_and_sample_parser_assert.svh"

module wavp_parse
    import wavp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       file_start,
    output logic       res_valid,
    output result_t    res
);

    phase_t      phase_reg,    phase_next;
    logic [5:0]  offset_reg,   offset_next;
    logic [31:0] shift_reg,    shift_next;
    logic [7:0]  low_reg,      low_next;
    logic        parity_reg,   parity_next;
    logic [30:0] total_reg,    total_next;
    logic [30:0] done_reg,     done_next;
    logic [15:0] format_reg,   format_next;
    logic [15:0] chan_reg,     chan_next;
    logic [31:0] rate_reg,     rate_next;
    logic [15:0] bits_reg,     bits_next;

    tag_byte_t   tag;
    logic [31:0] shifted;
    logic [30:0] done_inc;

    always_comb
    begin
        // file_start restarts the parser before this byte is handled
        phase_next  = file_start ? PH_HEADER : phase_reg;
        offset_next = file_start ? 6'd0  : offset_reg;
        shift_next  = file_start ? 32'd0 : shift_reg;
        low_next    = file_start ? 8'd0  : low_reg;
        parity_next = file_start ? 1'b0  : parity_reg;
        total_next  = file_start ? 31'd0 : total_reg;
        done_next   = file_start ? 31'd0 : done_reg;
        format_next = file_start ? 16'd0 : format_reg;
        chan_next   = file_start ? 16'd0 : chan_reg;
        rate_next   = file_start ? 32'd0 : rate_reg;
        bits_next   = file_start ? 16'd0 : bits_reg;

        res       = '0;
        res_valid = 1'b0;
        tag       = tag_lookup(offset_next);
        shifted   = {data_byte, shift_next[31:8]};
        done_inc  = done_next + 31'd1;

        unique case (phase_next)
            PH_HEADER:
            begin
                if (tag.check && (data_byte != tag.value))
                begin
                    phase_next         = PH_IDLE;
                    res_valid          = 1'b1;
                    res.kind           = KIND_ERROR;
                    res.error_position = offset_next;
                end
                else
                begin
                    shift_next = shifted;
                    if (offset_next == OFF_FORMAT_HI)
                        format_next = shifted[31:16];
                    if (offset_next == OFF_CHAN_HI)
                        chan_next = shifted[31:16];
                    if (offset_next == OFF_RATE_HI)
                        rate_next = shifted;
                    if (offset_next == OFF_BITS_HI)
                        bits_next = shifted[31:16];
                    if (offset_next == OFF_HDR_LAST)
                    begin
                        total_next          = shifted[31:1];
                        done_next           = 31'd0;
                        parity_next         = 1'b0;
                        phase_next          = (shifted[31:1] == 31'd0) ? PH_IDLE : PH_SAMPLES;
                        res_valid           = 1'b1;
                        res.kind            = KIND_HEADER;
                        res.audio_format    = format_next;
                        res.channel_count   = chan_next;
                        res.sample_rate     = rate_next;
                        res.bits_per_sample = bits_next;
                        res.sample_total    = shifted[31:1];
                        res.last_flag       = (shifted[31:1] == 31'd0);
                    end
                    else
                    begin
                        offset_next = offset_next + 6'd1;
                    end
                end
            end
            PH_SAMPLES:
            begin
                if (!parity_next)
                begin
                    low_next    = data_byte;
                    parity_next = 1'b1;
                end
                else
                begin
                    parity_next      = 1'b0;
                    res_valid        = 1'b1;
                    res.kind         = KIND_SAMPLE;
                    res.sample_value = signed'({data_byte, low_next});
                    res.sample_index = done_next;
                    done_next        = done_inc;
                    if (done_inc >= total_next)
                    begin
                        res.last_flag = 1'b1;
                        phase_next    = PH_IDLE;
                    end
                end
            end
            default:
            begin
                // idle or unused code: bytes are dropped until file_start
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            offset_reg <= 6'd0;
            shift_reg  <= 32'd0;
            low_reg    <= 8'd0;
            parity_reg <= 1'b0;
            total_reg  <= 31'd0;
            done_reg   <= 31'd0;
            format_reg <= 16'd0;
            chan_reg   <= 16'd0;
            rate_reg   <= 32'd0;
            bits_reg   <= 16'd0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            offset_reg <= offset_next;
            shift_reg  <= shift_next;
            low_reg    <= low_next;
            parity_reg <= parity_next;
            total_reg  <= total_next;
            done_reg   <= done_next;
            format_reg <= format_next;
            chan_reg   <= chan_next;
            rate_reg   <= rate_next;
            bits_reg   <= bits_next;
        end
    end

    `WAVP_ASSERT_ALWAYS(a_samples_nonzero, clk, rst_n, (phase_reg != PH_SAMPLES) || (total_reg != 31'd0), "sample phase with zero sample total")
    `WAVP_ASSERT_ALWAYS(a_done_below_total, clk, rst_n, (phase_reg != PH_SAMPLES) || (done_reg < total_reg), "sample count ran past total")
    `WAVP_ASSERT_ALWAYS(a_offset_in_header, clk, rst_n, (phase_reg != PH_HEADER) || (offset_reg <= OFF_HDR_LAST), "header offset beyond header")

endmodule

### rtl/core/wavp_out_fifo.sv
`timescale 1ns / 1ps

`include "wav_header_and_sample_parser_assert.svh"

module wavp_out_fifo
    import wavp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    input  logic    pop,
    output logic    full,
    output logic    out_valid,
    output result_t out_data
);

    result_t    slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot_reg[rd_ptr_reg];

    `WAVP_ASSERT_ALWAYS(a_count_range, clk, rst_n, count_reg != 2'd3, "result queue count out of range")
    `WAVP_ASSERT_ALWAYS(a_no_overflow, clk, rst_n, !(push && full), "push into full result queue")
    `WAVP_ASSERT_NEXT(a_fill, clk, rst_n, push && !pop && (count_reg == 2'd1), full, "queue did not fill")

endmodule

### rtl/core/wav_header_and_sample_parser.sv
// Channel   Handshake                  Payload
// byte      byte_valid / byte_stall    data_byte, file_start
// result    result_valid / result_stall result_kind .. error_position
//
// One byte is taken per cycle while byte_stall is low; its result is registered.
// Header checks and sample assembly are one combinational pass into a
// two-entry result queue, which keeps the input moving while a result waits.
// byte_stall rises only when both queue entries are held by result_stall.
// rst_n (async, active low) returns the parser to header offset 0.
`timescale 1ns / 1ps

module wav_header_and_sample_parser
    import wavp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  logic [7:0]         data_byte,
    input  logic               file_start,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [1:0]         result_kind,
    output logic [15:0]        audio_format,
    output logic [15:0]        channel_count,
    output logic [31:0]        sample_rate,
    output logic [15:0]        bits_per_sample,
    output logic [30:0]        sample_total,
    output logic signed [15:0] sample_value,
    output logic [30:0]        sample_index,
    output logic               last_flag,
    output logic [5:0]         error_position
);

    logic    accept;
    logic    res_valid;
    result_t res;
    result_t out_data;
    logic    full;

    assign byte_stall = full;
    assign accept     = byte_valid && !full;

    wavp_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (data_byte),
        .file_start (file_start),
        .res_valid  (res_valid),
        .res        (res)
    );

    wavp_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && res_valid),
        .push_data (res),
        .pop       (result_valid && !result_stall),
        .full      (full),
        .out_valid (result_valid),
        .out_data  (out_data)
    );

    assign result_kind     = out_data.kind;
    assign audio_format    = out_data.audio_format;
    assign channel_count   = out_data.channel_count;
    assign sample_rate     = out_data.sample_rate;
    assign bits_per_sample = out_data.bits_per_sample;
    assign sample_total    = out_data.sample_total;
    assign sample_value    = out_data.sample_value;
    assign sample_index    = out_data.sample_index;
    assign last_flag       = out_data.last_flag;
    assign error_position  = out_data.error_position;

endmodule
